// File: src/qvr_pkg.sv
package qvr_pkg;

  // Field widths
  localparam int QW       = 32;          // quaternion component, Q2.30
  localparam int VW       = 32;          // vector component
  localparam int FRAC     = 60;          // fraction bits of a Q4.60 product
  localparam int NDIM     = 3;
  localparam int NQUAT    = 4;
  localparam int NPAIR    = 10;

  // Datapath widths
  localparam int PW       = 2 * QW;      // q_a * q_b
  localparam int DPW      = PW + 1;      // dq_a * q_b + q_a * dq_b
  localparam int MW       = DPW + 3;     // matrix entry, sum of four terms times two
  localparam int MW_LO    = 34;          // unsigned low slice of a matrix entry
  localparam int MW_HI    = MW - MW_LO;  // signed high slice
  localparam int LPW      = MW_LO + 1 + VW;
  localparam int HPW      = MW_HI + VW;
  localparam int LSW      = LPW + 2;
  localparam int HSW      = HPW + 2;
  localparam int AW       = 100;         // full dot product, rounded

  // Pipeline
  localparam int VEC_STAGES = 3;         // vector waits while the matrix settles
  localparam int PIPE_LAT   = 8;         // depth of the valid and end-of-batch pipelines

  // Configuration port
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int RIDX_W   = 3;

  localparam logic [RIDX_W-1:0] REG_QUAT_W  = 3'd0;
  localparam logic [RIDX_W-1:0] REG_QUAT_X  = 3'd1;
  localparam logic [RIDX_W-1:0] REG_QUAT_Y  = 3'd2;
  localparam logic [RIDX_W-1:0] REG_QUAT_Z  = 3'd3;
  localparam logic [RIDX_W-1:0] REG_DQUAT_W = 3'd4;
  localparam logic [RIDX_W-1:0] REG_DQUAT_X = 3'd5;
  localparam logic [RIDX_W-1:0] REG_DQUAT_Y = 3'd6;
  localparam logic [RIDX_W-1:0] REG_DQUAT_Z = 3'd7;

  localparam logic signed [QW-1:0] QUAT_W_RST = 32'sh4000_0000;

  localparam logic signed [AW-1:0] ROUND_BIAS = AW'(1) << (FRAC - 1);
  localparam logic signed [VW-1:0] SAT_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [VW-1:0] SAT_MIN    = 32'sh8000_0000;

  // Quaternion component pairs, named by their component indices
  localparam int P00 = 0;
  localparam int P11 = 1;
  localparam int P22 = 2;
  localparam int P33 = 3;
  localparam int P01 = 4;
  localparam int P02 = 5;
  localparam int P03 = 6;
  localparam int P12 = 7;
  localparam int P13 = 8;
  localparam int P23 = 9;

  localparam logic [1:0] PAIR_A [NPAIR] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0,
                                            2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [NPAIR] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                            2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  typedef logic signed [QW-1:0]  quat_t   [NQUAT];
  typedef logic signed [VW-1:0]  vec_t    [NDIM];
  typedef logic signed [MW-1:0]  ent_t;
  typedef ent_t                  row_t    [NDIM];
  typedef ent_t                  mat_t    [NDIM][NDIM];
  typedef logic signed [DPW-1:0] pair_arr_t [NPAIR];

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 sat;
  } dot_res_t;

endpackage

// File: src/qvr_coef.sv
module qvr_coef (
  input  logic           clk_i,
  input  qvr_pkg::quat_t quat_i,
  input  qvr_pkg::quat_t dquat_i,
  output qvr_pkg::mat_t  rot_m_o,
  output qvr_pkg::mat_t  der_m_o
);
  import qvr_pkg::*;

  logic signed [PW-1:0] prod_d [NPAIR];
  logic signed [PW-1:0] prod_q [NPAIR];
  logic signed [PW-1:0] dl_d   [NPAIR];
  logic signed [PW-1:0] dl_q   [NPAIR];
  logic signed [PW-1:0] dr_d   [NPAIR];
  logic signed [PW-1:0] dr_q   [NPAIR];
  pair_arr_t            ps_d;
  pair_arr_t            ps_q;
  pair_arr_t            ds_d;
  pair_arr_t            ds_q;
  mat_t                 rot_m_d;
  mat_t                 rot_m_q;
  mat_t                 der_m_d;
  mat_t                 der_m_q;

  function automatic ent_t diag4(input logic signed [DPW-1:0] a, input logic signed [DPW-1:0] b,
                                 input logic signed [DPW-1:0] c, input logic signed [DPW-1:0] d);
    return MW'(a) + MW'(b) - MW'(c) - MW'(d);
  endfunction

  function automatic ent_t twice(input logic signed [DPW-1:0] a, input logic signed [DPW-1:0] b,
                                 input logic sub);
    ent_t s;
    s = sub ? (MW'(a) - MW'(b)) : (MW'(a) + MW'(b));
    return s <<< 1;
  endfunction

  // Rotation matrix of q * v * conj(q) in terms of the ten pair products
  function automatic void build_mat(input pair_arr_t p, output mat_t m);
    m[0][0] = diag4(p[P00], p[P11], p[P22], p[P33]);
    m[0][1] = twice(p[P12], p[P03], 1'b1);
    m[0][2] = twice(p[P13], p[P02], 1'b0);
    m[1][0] = twice(p[P12], p[P03], 1'b0);
    m[1][1] = diag4(p[P00], p[P22], p[P11], p[P33]);
    m[1][2] = twice(p[P23], p[P01], 1'b1);
    m[2][0] = twice(p[P13], p[P02], 1'b1);
    m[2][1] = twice(p[P23], p[P01], 1'b0);
    m[2][2] = diag4(p[P00], p[P33], p[P11], p[P22]);
  endfunction

  // Pair products and their two derivative terms, one multiplier each
  always_comb begin
    for (int k = 0; k < NPAIR; k++) begin
      prod_d[k] = PW'(quat_i[PAIR_A[k]])  * PW'(quat_i[PAIR_B[k]]);
      dl_d[k]   = PW'(dquat_i[PAIR_A[k]]) * PW'(quat_i[PAIR_B[k]]);
      dr_d[k]   = PW'(quat_i[PAIR_A[k]])  * PW'(dquat_i[PAIR_B[k]]);
    end
  end

  // Product rule: d(a*b) = da*b + a*db
  always_comb begin
    for (int k = 0; k < NPAIR; k++) begin
      ps_d[k] = DPW'(prod_q[k]);
      ds_d[k] = DPW'(dl_q[k]) + DPW'(dr_q[k]);
    end
  end

  always_comb begin
    build_mat(ps_q, rot_m_d);
    build_mat(ds_q, der_m_d);
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    dl_q    <= dl_d;
    dr_q    <= dr_d;
    ps_q    <= ps_d;
    ds_q    <= ds_d;
    rot_m_q <= rot_m_d;
    der_m_q <= der_m_d;
  end

  assign rot_m_o = rot_m_q;
  assign der_m_o = der_m_q;

endmodule

// File: src/qvr_dot.sv
module qvr_dot (
  input  logic              clk_i,
  input  qvr_pkg::row_t     m_i,
  input  qvr_pkg::vec_t     v_i,
  output qvr_pkg::dot_res_t res_o
);
  import qvr_pkg::*;

  logic signed [LPW-1:0]   lo_prod_d [NDIM];
  logic signed [LPW-1:0]   lo_prod_q [NDIM];
  logic signed [HPW-1:0]   hi_prod_d [NDIM];
  logic signed [HPW-1:0]   hi_prod_q [NDIM];
  logic signed [LSW-1:0]   lo_sum_d;
  logic signed [LSW-1:0]   lo_sum_q;
  logic signed [HSW-1:0]   hi_sum_d;
  logic signed [HSW-1:0]   hi_sum_q;
  logic signed [AW-1:0]    acc_d;
  logic signed [AW-1:0]    acc_q;
  logic [AW-FRAC-VW:0]     upper;
  logic                    in_range;
  dot_res_t                res_d;
  dot_res_t                res_q;

  // Split each entry into an unsigned low slice and a signed high slice
  always_comb begin
    for (int c = 0; c < NDIM; c++) begin
      lo_prod_d[c] = LPW'($signed({1'b0, m_i[c][MW_LO-1:0]})) * LPW'(v_i[c]);
      hi_prod_d[c] = HPW'($signed(m_i[c][MW-1:MW_LO]))       * HPW'(v_i[c]);
    end
  end

  always_comb begin
    lo_sum_d = LSW'(lo_prod_q[0]) + LSW'(lo_prod_q[1]) + LSW'(lo_prod_q[2]);
    hi_sum_d = HSW'(hi_prod_q[0]) + HSW'(hi_prod_q[1]) + HSW'(hi_prod_q[2]);
  end

  // Recombine the slices and add half an output LSB
  assign acc_d = (AW'(hi_sum_q) <<< MW_LO) + AW'(lo_sum_q) + ROUND_BIAS;

  // Result fits when every bit above the output's sign bit matches it
  always_comb begin
    upper       = acc_q[AW-1:FRAC+VW-1];
    in_range    = (&upper) || !(|upper);
    res_d.sat   = !in_range;
    if (in_range) begin
      res_d.value = acc_q[FRAC+VW-1:FRAC];
    end else if (acc_q[AW-1]) begin
      res_d.value = SAT_MIN;
    end else begin
      res_d.value = SAT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_prod_q <= lo_prod_d;
    hi_prod_q <= hi_prod_d;
    lo_sum_q  <= lo_sum_d;
    hi_sum_q  <= hi_sum_d;
    acc_q     <= acc_d;
    res_q     <= res_d;
  end

  assign res_o = res_q;

endmodule

// File: src/quaternion_vector_rotate.sv
// Channel   Handshake              Payload
// -------   ---------------------  ------------------------------------------------
// input     start / busy           vec_x_i, vec_y_i, vec_z_i, last_in_i
// result    out_valid_o (strobe)   rot_*_o, der_*_o, overflow_o, last_out_o
// config    APB psel/penable/...   quat_w..dquat_z at byte address 4*index
//
// One vector is taken per cycle; busy is never raised. Each result comes out
// on out_valid_o after its transfer has passed the 8 register stages of the
// path: the vector delay registers that cover the 3-deep coefficient pipeline,
// four stages of the dot-product unit and the output register. Reset clears
// the valid pipeline and loads the identity quaternion.
// The result side has no back-pressure: each result is shown for one cycle.
module quaternion_vector_rotate (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // Command-style input
  input  logic                           start,
  output logic                           busy,
  input  logic signed [qvr_pkg::VW-1:0]  vec_x_i,
  input  logic signed [qvr_pkg::VW-1:0]  vec_y_i,
  input  logic signed [qvr_pkg::VW-1:0]  vec_z_i,
  input  logic                           last_in_i,

  // Result strobe
  output logic                           out_valid_o,
  output logic signed [qvr_pkg::VW-1:0]  rot_x_o,
  output logic signed [qvr_pkg::VW-1:0]  rot_y_o,
  output logic signed [qvr_pkg::VW-1:0]  rot_z_o,
  output logic signed [qvr_pkg::VW-1:0]  der_x_o,
  output logic signed [qvr_pkg::VW-1:0]  der_y_o,
  output logic signed [qvr_pkg::VW-1:0]  der_z_o,
  output logic                           overflow_o,
  output logic                           last_out_o,

  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qvr_pkg::PADDR_W-1:0]    paddr,
  input  logic [qvr_pkg::PDATA_W-1:0]    pwdata,
  output logic [qvr_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import qvr_pkg::*;

  logic                 accept;
  logic                 cfg_wr;
  logic [RIDX_W-1:0]    ridx;

  quat_t                quat_q;
  quat_t                dquat_q;

  logic [PIPE_LAT-1:0]  vld_d;
  logic [PIPE_LAT-1:0]  vld_q;
  logic [PIPE_LAT-1:0]  last_d;
  logic [PIPE_LAT-1:0]  last_q;

  vec_t                 vec_in;
  vec_t                 vec_q [VEC_STAGES];

  mat_t                 rot_m;
  mat_t                 der_m;
  dot_res_t             rot_res [NDIM];
  dot_res_t             der_res [NDIM];

  logic signed [VW-1:0] rot_q [NDIM];
  logic signed [VW-1:0] der_q [NDIM];
  logic                 ovf_d;
  logic                 ovf_q;

  // Never stall the input: every stage advances each cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign ridx   = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[0] <= QUAT_W_RST;
      for (int i = 1; i < NQUAT; i++) begin
        quat_q[i] <= '0;
      end
      for (int i = 0; i < NQUAT; i++) begin
        dquat_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (ridx)
        REG_QUAT_W:  quat_q[0]  <= pwdata;
        REG_QUAT_X:  quat_q[1]  <= pwdata;
        REG_QUAT_Y:  quat_q[2]  <= pwdata;
        REG_QUAT_Z:  quat_q[3]  <= pwdata;
        REG_DQUAT_W: dquat_q[0] <= pwdata;
        REG_DQUAT_X: dquat_q[1] <= pwdata;
        REG_DQUAT_Y: dquat_q[2] <= pwdata;
        REG_DQUAT_Z: dquat_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_QUAT_W:  prdata = quat_q[0];
      REG_QUAT_X:  prdata = quat_q[1];
      REG_QUAT_Y:  prdata = quat_q[2];
      REG_QUAT_Z:  prdata = quat_q[3];
      REG_DQUAT_W: prdata = dquat_q[0];
      REG_DQUAT_X: prdata = dquat_q[1];
      REG_DQUAT_Y: prdata = dquat_q[2];
      REG_DQUAT_Z: prdata = dquat_q[3];
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Coefficient matrices: rotation and its derivative along dq. They depend
  // only on configuration, so they run freely and settle through the product,
  // sum and matrix registers after a write, before any vector reaches the multipliers.
  // ---------------------------------------------------------------------------
  qvr_coef u_coef (
    .clk_i   (clk_i),
    .quat_i  (quat_q),
    .dquat_i (dquat_q),
    .rot_m_o (rot_m),
    .der_m_o (der_m)
  );

  // ---------------------------------------------------------------------------
  // Valid and end-of-batch marks travel beside the data
  // ---------------------------------------------------------------------------
  assign vld_d  = {vld_q[PIPE_LAT-2:0], accept};
  assign last_d = {last_q[PIPE_LAT-2:0], last_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      last_q <= '0;
    end else begin
      vld_q  <= vld_d;
      last_q <= last_d;
    end
  end

  // Delay the vector through the vec_q registers so it meets a settled matrix
  assign vec_in[0] = vec_x_i;
  assign vec_in[1] = vec_y_i;
  assign vec_in[2] = vec_z_i;

  always_ff @(posedge clk_i) begin
    vec_q[0] <= vec_in;
    for (int s = 1; s < VEC_STAGES; s++) begin
      vec_q[s] <= vec_q[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Six dot products: one row of a matrix against the vector each
  // ---------------------------------------------------------------------------
  for (genvar r = 0; r < NDIM; r++) begin : g_row
    qvr_dot u_rot (
      .clk_i (clk_i),
      .m_i   (rot_m[r]),
      .v_i   (vec_q[VEC_STAGES-1]),
      .res_o (rot_res[r])
    );

    qvr_dot u_der (
      .clk_i (clk_i),
      .m_i   (der_m[r]),
      .v_i   (vec_q[VEC_STAGES-1]),
      .res_o (der_res[r])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: gather the six components and merge saturation flags
  // ---------------------------------------------------------------------------
  always_comb begin
    ovf_d = 1'b0;
    for (int r = 0; r < NDIM; r++) begin
      ovf_d = ovf_d | rot_res[r].sat | der_res[r].sat;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < NDIM; r++) begin
      rot_q[r] <= rot_res[r].value;
      der_q[r] <= der_res[r].value;
    end
    ovf_q <= ovf_d;
  end

  assign out_valid_o = vld_q[PIPE_LAT-1];
  assign last_out_o  = last_q[PIPE_LAT-1];
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign der_x_o     = der_q[0];
  assign der_y_o     = der_q[1];
  assign der_z_o     = der_q[2];
  assign overflow_o  = ovf_q;

endmodule
